### sv/u8dec_pkg.sv
// u8dec_pkg: shared widths and constants for the UTF-8 stream decoder.
// No dependencies; used by utf8_stream_decoder.
package u8dec_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned PEND_W = 2;

    localparam logic [CP_W-1:0] REPL_CHAR = 21'h00FFFD;

    // payload masks for lead and continuation bytes
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

    // continuation byte tag in the top two bits
    localparam logic [1:0] CONT_TAG = 2'b10;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

endpackage

### sv/utf8_stream_decoder.sv
// utf8_stream_decoder: byte-in, code-point-out UTF-8 decoder with U+FFFD on errors.
// Depends on u8dec_pkg.
//
//  channel | dir | ports                                        | beat carries
//  --------+-----+----------------------------------------------+--------------------------
//  s_      | in  | s_valid s_ready s_data_byte s_final_byte     | one raw byte, end flag
//  m_      | out | m_valid m_ready m_code_point m_was_invalid   | one code point or U+FFFD
//          |     |           m_end_of_text                      |
//
// One byte per cycle sustained while m_ready is high. A byte goes from the input register
// through the decode logic into the result register, which drives m_valid.
// Opening lead bytes and inner continuation bytes produce no result beat unless final.
// aresetn (synchronous) empties both registers and closes any open sequence.
// A stall on m_ready backs up into s_ready once both registers hold a beat.
module utf8_stream_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [u8dec_pkg::BYTE_W-1:0]  s_data_byte,
    input  logic                          s_final_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [u8dec_pkg::CP_W-1:0]    m_code_point,
    output logic                          m_was_invalid,
    output logic                          m_end_of_text
);

    // input register
    logic                          in_valid_reg, in_valid_next;
    logic [u8dec_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                          in_final_reg;

    // decoder state
    logic [u8dec_pkg::CP_W-1:0]    partial_reg, partial_next;
    logic [u8dec_pkg::PEND_W-1:0]  pend_reg, pend_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic [u8dec_pkg::CP_W-1:0]    out_cp_reg;
    logic                          out_bad_reg;
    logic                          out_eot_reg;

    logic                          out_free;
    logic                          proc;
    logic                          emit;
    logic [u8dec_pkg::CP_W-1:0]    emit_cp;
    logic                          emit_bad;
    logic [u8dec_pkg::CP_W-1:0]    acc;
    logic [u8dec_pkg::PEND_W-1:0]  pend_dec;

    assign out_free = !out_valid_reg || m_ready;
    assign proc     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign acc      = {partial_reg[u8dec_pkg::CP_W-7:0], in_byte_reg[5:0]};
    assign pend_dec = pend_reg - u8dec_pkg::PEND_ONE;

    always_comb begin
        emit         = 1'b0;
        emit_cp      = u8dec_pkg::CP_W'(in_byte_reg);
        emit_bad     = 1'b0;
        partial_next = partial_reg;
        pend_next    = pend_reg;

        if (pend_reg == u8dec_pkg::PEND_NONE) begin
            case (in_byte_reg) inside
                [8'h00:8'h7F]: begin
                    emit = 1'b1;
                end
                [8'hC0:8'hDF]: begin
                    partial_next = u8dec_pkg::CP_W'(in_byte_reg & u8dec_pkg::LEAD2_MASK);
                    pend_next    = u8dec_pkg::PEND_ONE;
                end
                [8'hE0:8'hEF]: begin
                    partial_next = u8dec_pkg::CP_W'(in_byte_reg & u8dec_pkg::LEAD3_MASK);
                    pend_next    = u8dec_pkg::PEND_TWO;
                end
                [8'hF0:8'hF7]: begin
                    partial_next = u8dec_pkg::CP_W'(in_byte_reg & u8dec_pkg::LEAD4_MASK);
                    pend_next    = u8dec_pkg::PEND_THREE;
                end
                default: begin
                    // stray continuation or 0xF8..0xFF
                    emit     = 1'b1;
                    emit_cp  = u8dec_pkg::REPL_CHAR;
                    emit_bad = 1'b1;
                end
            endcase
            // text ends right after a lead byte
            if (!emit && in_final_reg) begin
                emit         = 1'b1;
                emit_cp      = u8dec_pkg::REPL_CHAR;
                emit_bad     = 1'b1;
                partial_next = '0;
                pend_next    = u8dec_pkg::PEND_NONE;
            end
        end else if (in_byte_reg[7:6] != u8dec_pkg::CONT_TAG) begin
            // bad continuation: byte is consumed, sequence dropped
            emit         = 1'b1;
            emit_cp      = u8dec_pkg::REPL_CHAR;
            emit_bad     = 1'b1;
            partial_next = '0;
            pend_next    = u8dec_pkg::PEND_NONE;
        end else if (pend_dec == u8dec_pkg::PEND_NONE) begin
            emit         = 1'b1;
            emit_cp      = acc;
            partial_next = '0;
            pend_next    = u8dec_pkg::PEND_NONE;
        end else if (in_final_reg) begin
            emit         = 1'b1;
            emit_cp      = u8dec_pkg::REPL_CHAR;
            emit_bad     = 1'b1;
            partial_next = '0;
            pend_next    = u8dec_pkg::PEND_NONE;
        end else begin
            partial_next = acc;
            pend_next    = pend_dec;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end

        out_valid_next = out_valid_reg;
        if (proc && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            partial_reg   <= '0;
            pend_reg      <= u8dec_pkg::PEND_NONE;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc) begin
                partial_reg <= partial_next;
                pend_reg    <= pend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_final_reg <= s_final_byte;
        end
        if (proc && emit) begin
            out_cp_reg  <= emit_cp;
            out_bad_reg <= emit_bad;
            out_eot_reg <= in_final_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_code_point  = out_cp_reg;
    assign m_was_invalid = out_bad_reg;
    assign m_end_of_text = out_eot_reg;

    // a final byte always leaves no sequence open
    a_final_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_final_reg) |=> (pend_reg == u8dec_pkg::PEND_NONE))
        else $error("sequence still open after final byte");

    // a final byte always produces a beat
    a_final_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && in_final_reg) |=> (out_valid_reg && out_eot_reg))
        else $error("final byte produced no result beat");

    // accumulator is clear whenever no sequence is open
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg == u8dec_pkg::PEND_NONE) |-> (partial_reg == '0))
        else $error("partial value left over with no open sequence");

    // error beats carry the replacement character
    a_repl: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_bad_reg) |-> (out_cp_reg == u8dec_pkg::REPL_CHAR))
        else $error("error beat without U+FFFD");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> (!out_valid_reg && !in_valid_reg))
        else $error("registers not empty after reset");

endmodule
